// ===== src/gfcc_pkg.sv =====
`timescale 1ns / 1ps

package gfcc_pkg;

  // Default sizes, handed down from the top level
  localparam int AXIS_FRAC_BITS_DEF = 14;
  localparam int COUNTER_BITS_DEF   = 8;

  // Number of hold-off counters: eight actions plus the camera counter
  localparam int N_ACT = 9;
  localparam int N_AXIS = 4;

  // Action indexes (action_enable / action_buttons bit order)
  localparam int ACT_TAKEOFF   = 0;
  localparam int ACT_LAND      = 1;
  localparam int ACT_VIEW      = 2;
  localparam int ACT_PHOTO     = 3;
  localparam int ACT_RECORD    = 4;
  localparam int ACT_FLIP      = 5;
  localparam int ACT_SLOW      = 6;
  localparam int ACT_EMERGENCY = 7;
  localparam int ACT_CAMERA    = 8;

  // Axis indexes
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_CLIMB = 2;
  localparam int AX_YAW   = 3;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTION_ENABLE    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAIR_MODE        = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ENABLE      = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAMERA_SUPPORTED = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_OFF_TICKS   = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAMERA_HOLD_OFF  = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ARM_HOLD_TICKS   = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_ZONE        = 4'd7;
  localparam int CFG_DATA_BITS = 15;

  typedef struct packed {
    logic [8:0]  action_enable;
    logic [3:0]  pair_mode;
    logic [3:0]  axis_enable;
    logic        camera_supported;
    logic [7:0]  hold_off_ticks;
    logic [7:0]  camera_hold_off;
    logic [6:0]  arm_hold_ticks;
    logic [14:0] dead_zone;
  } cfg_t;

  typedef struct packed {
    logic               device_present;
    logic [8:0]         action_buttons;
    logic [7:0]         direction_buttons;
    logic signed [15:0] roll_stick;
    logic signed [15:0] pitch_stick;
    logic signed [15:0] height_stick;
    logic signed [15:0] yaw_stick;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         action_pulses;
    logic               arm_request;
    logic               camera_valid;
    logic signed [7:0]  camera_tilt;
    logic signed [7:0]  camera_pan;
    logic               hover;
    logic signed [15:0] roll_out;
    logic signed [15:0] pitch_out;
    logic signed [15:0] yaw_out;
    logic signed [15:0] climb_out;
  } out_word_t;

endpackage

// ===== src/gamepad_flight_command_conditioner_unit.sv =====
`timescale 1ns / 1ps
// Gamepad flight command conditioner.
// Input channel (in_valid / in_stall / in_data): one word per control tick holding the
// presence flag, action buttons, direction buttons and four stick axes.
// Output channel (out_valid / out_stall / out_data): exactly one result word per input word,
// in order: action pulses, arm request, camera command, hover flag and four conditioned axes.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is always
// high; write only while no word is in flight. Indexes outside the register list are dropped.
// Registers: the accepted word lands in the input register, then its result in the result
// register, which drives out_valid and out_data.
// Throughput: one word per cycle while the receiver does not stall; the only loop is the
// counter/countdown update, which closes within the single logic stage between the two registers.
// Stall: when the receiver stalls with a result waiting, the input register still takes one
// more word; after that in_stall rises until the result word is taken.
// Reset (rst, synchronous): both registers empty, hold-off counters and arm countdown zero,
// configuration registers at their defaults (hold-off 16, camera hold-off 8, arm hold 100,
// dead zone 1638, everything else zero).
module gamepad_flight_command_conditioner_unit #(
  parameter int AXIS_FRAC_BITS = gfcc_pkg::AXIS_FRAC_BITS_DEF,
  parameter int COUNTER_BITS   = gfcc_pkg::COUNTER_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  gfcc_pkg::in_word_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output gfcc_pkg::out_word_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gfcc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [gfcc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import gfcc_pkg::*;

  // Input register
  logic      in_q_valid;
  in_word_t  in_q;
  // Pipe moves when the result register is empty or being drained
  logic      advance;
  logic      step;
  cfg_t      cfg;
  out_word_t result;
  logic      slow;

  logic [AXIS_FRAC_BITS:0] lane_mag [4];
  logic [3:0]              lane_neg;
  logic signed [15:0]      lane_stick [4];

  assign advance   = !out_valid || !out_stall;
  assign step      = in_q_valid && advance;
  assign in_stall  = in_q_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  // Payload: load only on an accepted word, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.action_enable    <= '0;
      cfg.pair_mode        <= '0;
      cfg.axis_enable      <= '0;
      cfg.camera_supported <= 1'b0;
      cfg.hold_off_ticks   <= 8'd16;
      cfg.camera_hold_off  <= 8'd8;
      cfg.arm_hold_ticks   <= 7'd100;
      cfg.dead_zone        <= 15'd1638;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTION_ENABLE:    cfg.action_enable    <= cfg_data[8:0];
        REG_PAIR_MODE:        cfg.pair_mode        <= cfg_data[3:0];
        REG_AXIS_ENABLE:      cfg.axis_enable      <= cfg_data[3:0];
        REG_CAMERA_SUPPORTED: cfg.camera_supported <= cfg_data[0];
        REG_HOLD_OFF_TICKS:   cfg.hold_off_ticks   <= cfg_data[7:0];
        REG_CAMERA_HOLD_OFF:  cfg.camera_hold_off  <= cfg_data[7:0];
        REG_ARM_HOLD_TICKS:   cfg.arm_hold_ticks   <= cfg_data[6:0];
        REG_DEAD_ZONE:        cfg.dead_zone        <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  assign lane_stick[AX_ROLL]  = in_q.roll_stick;
  assign lane_stick[AX_PITCH] = in_q.pitch_stick;
  assign lane_stick[AX_CLIMB] = in_q.height_stick;
  assign lane_stick[AX_YAW]   = in_q.yaw_stick;

  // One lane per axis: source select, clamp, slow-mode scale, dead zone.
  // Height is negated to give climb; roll and pitch scale by 3/10, climb and yaw by 1/2.
  for (genvar g = 0; g < N_AXIS; g++) begin : g_lane
    gfcc_axis #(
      .AXIS_FRAC_BITS(AXIS_FRAC_BITS)
    ) u_axis (
      .pair_sel (cfg.pair_mode[g]),
      .stick_sel(cfg.axis_enable[g]),
      .negate   ((g == AX_CLIMB) ? 1'b1 : 1'b0),
      .tenths   ((g == AX_ROLL || g == AX_PITCH) ? 1'b1 : 1'b0),
      .plus     (in_q.direction_buttons[2*g]),
      .minus    (in_q.direction_buttons[2*g+1]),
      .stick    (lane_stick[g]),
      .slow     (slow),
      .dead_zone(cfg.dead_zone),
      .mag      (lane_mag[g]),
      .neg      (lane_neg[g])
    );
  end

  // Hold-off counters, action pulses, camera chord, arm countdown, result assembly
  gfcc_ctrl #(
    .AXIS_FRAC_BITS(AXIS_FRAC_BITS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .present(in_q.device_present),
    .buttons(in_q.action_buttons),
    .cfg    (cfg),
    .mag    (lane_mag),
    .neg    (lane_neg),
    .slow   (slow),
    .result (result)
  );

endmodule

// ===== src/gfcc_axis.sv =====
`timescale 1ns / 1ps

module gfcc_axis #(
  parameter int AXIS_FRAC_BITS = gfcc_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                      pair_sel,
  input  logic                      stick_sel,
  input  logic                      negate,
  input  logic                      tenths,
  input  logic                      plus,
  input  logic                      minus,
  input  logic signed [15:0]        stick,
  input  logic                      slow,
  input  logic [14:0]               dead_zone,
  output logic [AXIS_FRAC_BITS:0]   mag,
  output logic                      neg
);
  import gfcc_pkg::*;

  localparam int MW = AXIS_FRAC_BITS + 1;
  localparam int AW = (AXIS_FRAC_BITS + 3 > 18) ? AXIS_FRAC_BITS + 3 : 18;
  // floor(3m/10) as (m * K3) >> S, exact for m up to one
  localparam int S  = AXIS_FRAC_BITS + 5;
  localparam int K3 = (3 * (2 ** S) + 9) / 10;
  localparam logic [AW-1:0] ONE_W = AW'(1) << AXIS_FRAC_BITS;

  logic signed [AW-1:0] v_ext;
  logic signed [AW-1:0] v_src;
  logic [AW-1:0]        v_abs;
  logic [MW-1:0]        m_raw;
  logic [MW-1:0]        m_scaled;
  logic [MW+S-1:0]      prod;
  logic                 s_raw;

  always_comb begin
    v_ext = {{(AW-16){stick[15]}}, stick};
    v_src = negate ? -v_ext : v_ext;
    v_abs = v_src[AW-1] ? -v_src : v_src;

    // Pick the source, keep sign and clamped magnitude apart
    priority if (pair_sel) begin
      s_raw = minus & ~plus;
      m_raw = (plus ^ minus) ? ONE_W[MW-1:0] : '0;
    end else if (stick_sel) begin
      s_raw = v_src[AW-1];
      m_raw = (v_abs > ONE_W) ? ONE_W[MW-1:0] : v_abs[MW-1:0];
    end else begin
      s_raw = 1'b0;
      m_raw = '0;
    end

    prod = {{S{1'b0}}, m_raw} * (MW+S)'(K3);

    priority if (!slow) begin
      m_scaled = m_raw;
    end else if (tenths) begin
      m_scaled = prod[S +: MW];
    end else begin
      m_scaled = m_raw >> 1;
    end

    // Drop small deflections
    if (AW'(m_scaled) < AW'(dead_zone)) begin
      mag = '0;
      neg = 1'b0;
    end else begin
      mag = m_scaled;
      neg = s_raw;
    end
  end

endmodule

// ===== src/gfcc_ctrl.sv =====
`timescale 1ns / 1ps

module gfcc_ctrl #(
  parameter int AXIS_FRAC_BITS = gfcc_pkg::AXIS_FRAC_BITS_DEF,
  parameter int COUNTER_BITS   = gfcc_pkg::COUNTER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    present,
  input  logic [8:0]              buttons,
  input  gfcc_pkg::cfg_t          cfg,
  input  logic [AXIS_FRAC_BITS:0] mag [4],
  input  logic [3:0]              neg,
  output logic                    slow,
  output gfcc_pkg::out_word_t     result
);
  import gfcc_pkg::*;

  localparam int CW = COUNTER_BITS;
  localparam int XW = COUNTER_BITS + 8;
  localparam int MW = AXIS_FRAC_BITS + 1;
  localparam int AW = (AXIS_FRAC_BITS + 3 > 18) ? AXIS_FRAC_BITS + 3 : 18;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam int ARM_LEVEL = ((2 ** AXIS_FRAC_BITS) * 9) / 10;
  localparam logic [MW-1:0] ARM_W = MW'(ARM_LEVEL);

  logic [CW-1:0]        cnt      [N_ACT];
  logic [CW-1:0]        cnt_next [N_ACT];
  logic [CW-1:0]        dec      [N_ACT];
  logic [N_ACT-1:0]     fire;
  logic [CW-1:0]        reload_act;
  logic [CW-1:0]        reload_cam;
  logic [XW-1:0]        ext_act;
  logic [XW-1:0]        ext_cam;
  logic                 chord;
  logic [MW-1:0]        mag_eff [4];
  logic signed [AW-1:0] val     [4];
  logic                 gesture;
  logic signed [7:0]    arm;
  logic signed [7:0]    arm_next;
  logic signed [7:0]    arm_dec;
  logic                 arm_req;
  logic [MW+6:0]        tilt_prod;
  logic [MW+6:0]        pan_prod;
  logic [7:0]           tilt_mag;
  logic [7:0]           pan_mag;

  always_comb begin
    ext_act    = XW'(cfg.hold_off_ticks);
    ext_cam    = XW'(cfg.camera_hold_off);
    reload_act = (ext_act > XW'(CNT_MAX)) ? CNT_MAX : ext_act[CW-1:0];
    reload_cam = (ext_cam > XW'(CNT_MAX)) ? CNT_MAX : ext_cam[CW-1:0];

    // Advance every counter first, then test for zero
    for (int i = 0; i < N_ACT; i++) begin
      dec[i] = (cnt[i] != '0) ? cnt[i] - CW'(1) : '0;
    end
    for (int i = 0; i < N_ACT - 1; i++) begin
      fire[i] = present && cfg.action_enable[i] && buttons[i] && (dec[i] == '0);
    end
    chord = present && cfg.action_enable[ACT_CAMERA] && buttons[ACT_CAMERA];
    fire[ACT_CAMERA] = chord && (dec[ACT_CAMERA] == '0) && cfg.camera_supported;
    slow = fire[ACT_SLOW];
  end

  always_comb begin
    for (int i = 0; i < N_ACT; i++) begin
      if (fire[i]) begin
        cnt_next[i] = (i == ACT_CAMERA) ? reload_cam : reload_act;
      end else begin
        cnt_next[i] = dec[i];
      end
    end

    // Chord takes climb and yaw away from the vehicle
    for (int i = 0; i < N_AXIS; i++) begin
      mag_eff[i] = (chord && (i == AX_CLIMB || i == AX_YAW)) ? '0 : mag[i];
      val[i] = neg[i] ? -AW'(mag_eff[i]) : AW'(mag_eff[i]);
    end

    tilt_prod = {7'b0, mag[AX_CLIMB]} * (MW+7)'(100);
    pan_prod  = {7'b0, mag[AX_YAW]} * (MW+7)'(100);
    tilt_mag  = {1'b0, tilt_prod[AXIS_FRAC_BITS +: 7]};
    pan_mag   = {1'b0, pan_prod[AXIS_FRAC_BITS +: 7]};

    gesture = !neg[AX_PITCH] && (mag_eff[AX_PITCH] > ARM_W) &&
              neg[AX_CLIMB] && (mag_eff[AX_CLIMB] > ARM_W);
    arm_dec  = arm - 8'sd1;
    arm_req  = 1'b0;
    arm_next = arm;
    if (present) begin
      if (gesture) begin
        if (arm_dec <= 8'sd0) begin
          arm_req  = 1'b1;
          arm_next = {1'b0, cfg.arm_hold_ticks};
        end else begin
          arm_next = arm_dec;
        end
      end else begin
        arm_next = {1'b0, cfg.arm_hold_ticks};
      end
    end

    result = '0;
    if (!present) begin
      result.hover = 1'b1;
    end else begin
      result.action_pulses = {1'b0, fire[ACT_EMERGENCY], fire[ACT_FLIP:ACT_TAKEOFF]};
      result.arm_request   = arm_req;
      result.camera_valid  = fire[ACT_CAMERA];
      if (fire[ACT_CAMERA]) begin
        result.camera_tilt = neg[AX_CLIMB] ? -tilt_mag : tilt_mag;
        result.camera_pan  = neg[AX_YAW] ? -pan_mag : pan_mag;
      end
      result.hover = (mag_eff[AX_ROLL] == '0) && (mag_eff[AX_PITCH] == '0) &&
                     (mag_eff[AX_CLIMB] == '0) && (mag_eff[AX_YAW] == '0);
      result.roll_out  = val[AX_ROLL][15:0];
      result.pitch_out = val[AX_PITCH][15:0];
      result.yaw_out   = val[AX_YAW][15:0];
      result.climb_out = val[AX_CLIMB][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_ACT; i++) begin
        cnt[i] <= '0;
      end
      arm <= 8'sd0;
    end else if (step) begin
      for (int i = 0; i < N_ACT; i++) begin
        cnt[i] <= cnt_next[i];
      end
      arm <= arm_next;
    end
  end

endmodule

// ===== src/gfcc_checker.sv =====
`timescale 1ns / 1ps

module gfcc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input gfcc_pkg::out_word_t out_data
);
  import gfcc_pkg::*;

  // Hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // Empty pipe right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // No camera angles without a camera command
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.camera_valid |->
      out_data.camera_tilt == 8'sd0 && out_data.camera_pan == 8'sd0)
    else $error("camera angles without camera command");

  // Hover means every axis is zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hover |->
      out_data.roll_out == 16'sd0 && out_data.pitch_out == 16'sd0 &&
      out_data.yaw_out == 16'sd0 && out_data.climb_out == 16'sd0)
    else $error("hover with a nonzero axis");

  // Camera chord removes climb and yaw from the flight command
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.camera_valid |->
      out_data.climb_out == 16'sd0 && out_data.yaw_out == 16'sd0 && !out_data.arm_request)
    else $error("climb or yaw passed during camera command");

endmodule

bind gamepad_flight_command_conditioner_unit gfcc_checker u_gfcc_checker (.*);

// ===== tb/sv/gfcc_checker.sv =====
`timescale 1ns / 1ps

module gfcc_scoreboard (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  gfcc_pkg::in_word_t                 in_data,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  gfcc_pkg::out_word_t                out_data,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [gfcc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [gfcc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               wrap_up,
  output int                                 fail_count,
  output int                                 pending
);
  import gfcc_pkg::*;

  localparam int ONE = 1 << AXIS_FRAC_BITS_DEF;
  localparam int ARM_LEVEL = (ONE * 9) / 10;
  localparam int EMERGENCY_PULSE = 6;

  cfg_t settings;
  logic [COUNTER_BITS_DEF-1:0] holdoff [N_ACT];
  logic signed [7:0] arm_left;
  out_word_t expected_ticks [$];
  int miss_total = 0;
  int words_seen = 0;
  logic wrapped = 1'b0;

  function automatic int clamp_axis(input int v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic void take_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                       input logic [CFG_DATA_BITS-1:0] value);
    case (idx)
      REG_ACTION_ENABLE:    settings.action_enable = value[8:0];
      REG_PAIR_MODE:        settings.pair_mode = value[3:0];
      REG_AXIS_ENABLE:      settings.axis_enable = value[3:0];
      REG_CAMERA_SUPPORTED: settings.camera_supported = value[0];
      REG_HOLD_OFF_TICKS:   settings.hold_off_ticks = value[7:0];
      REG_CAMERA_HOLD_OFF:  settings.camera_hold_off = value[7:0];
      REG_ARM_HOLD_TICKS:   settings.arm_hold_ticks = value[6:0];
      REG_DEAD_ZONE:        settings.dead_zone = value[14:0];
      default: ;
    endcase
  endfunction

  // One control tick: advance the hold-off counters and arm countdown, return the result word.
  function automatic out_word_t condition_tick(input in_word_t w);
    out_word_t r;
    int ax [N_AXIS];
    int v;
    int mag;
    logic slow_now;
    logic chord;
    r = '0;
    slow_now = 1'b0;
    for (int i = 0; i < N_ACT; i++)
      if (holdoff[i] != 0) holdoff[i] = holdoff[i] - 1'b1;
    if (!w.device_present) begin
      r.hover = 1'b1;
      return r;
    end

    for (int i = 0; i < ACT_CAMERA; i++) begin
      if (settings.action_enable[i] && holdoff[i] == 0 && w.action_buttons[i]) begin
        if (i == ACT_SLOW) slow_now = 1'b1;
        else if (i == ACT_EMERGENCY) r.action_pulses[EMERGENCY_PULSE] = 1'b1;
        else r.action_pulses[i] = 1'b1;
        holdoff[i] = settings.hold_off_ticks;
      end
    end
    chord = settings.action_enable[ACT_CAMERA] && w.action_buttons[ACT_CAMERA];

    for (int a = 0; a < N_AXIS; a++) begin
      v = 0;
      if (settings.pair_mode[a]) begin
        v = (int'(w.direction_buttons[2*a]) - int'(w.direction_buttons[2*a+1])) * ONE;
      end else if (settings.axis_enable[a]) begin
        case (a)
          AX_ROLL:  v = w.roll_stick;
          AX_PITCH: v = w.pitch_stick;
          AX_CLIMB: begin
            v = w.height_stick;
            v = -v;
          end
          default:  v = w.yaw_stick;
        endcase
      end
      ax[a] = clamp_axis(v);
    end

    if (slow_now) begin
      ax[AX_ROLL] = (ax[AX_ROLL] * 3) / 10;
      ax[AX_PITCH] = (ax[AX_PITCH] * 3) / 10;
      ax[AX_CLIMB] = ax[AX_CLIMB] / 2;
      ax[AX_YAW] = ax[AX_YAW] / 2;
    end

    for (int a = 0; a < N_AXIS; a++) begin
      mag = (ax[a] < 0) ? -ax[a] : ax[a];
      if (mag < int'(settings.dead_zone)) ax[a] = 0;
    end

    if (chord) begin
      if (holdoff[ACT_CAMERA] == 0 && settings.camera_supported) begin
        holdoff[ACT_CAMERA] = settings.camera_hold_off;
        r.camera_valid = 1'b1;
        v = (ax[AX_CLIMB] * 100) / ONE;
        r.camera_tilt = v[7:0];
        v = (ax[AX_YAW] * 100) / ONE;
        r.camera_pan = v[7:0];
      end
      ax[AX_CLIMB] = 0;
      ax[AX_YAW] = 0;
    end

    if (ax[AX_PITCH] > ARM_LEVEL && ax[AX_CLIMB] < -ARM_LEVEL) begin
      arm_left = arm_left - 8'sd1;
      if (arm_left <= 0) begin
        r.arm_request = 1'b1;
        arm_left = $signed({1'b0, settings.arm_hold_ticks});
      end
    end else begin
      arm_left = $signed({1'b0, settings.arm_hold_ticks});
    end

    r.hover = (ax[AX_ROLL] == 0 && ax[AX_PITCH] == 0 && ax[AX_CLIMB] == 0 && ax[AX_YAW] == 0);
    r.roll_out = ax[AX_ROLL][15:0];
    r.pitch_out = ax[AX_PITCH][15:0];
    r.yaw_out = ax[AX_YAW][15:0];
    r.climb_out = ax[AX_CLIMB][15:0];
    return r;
  endfunction

  // Append one predicted word at the tail of the queue.
  task automatic queue_word(input out_word_t w);
    expected_ticks.insert(expected_ticks.size(), w);
  endtask

  task automatic cmp_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      miss_total++;
      if (miss_total <= 10)
        $display("result %0d: %s expected %h, got %h", words_seen, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      settings.action_enable = '0;
      settings.pair_mode = '0;
      settings.axis_enable = '0;
      settings.camera_supported = 1'b0;
      settings.hold_off_ticks = 8'd16;
      settings.camera_hold_off = 8'd8;
      settings.arm_hold_ticks = 7'd100;
      settings.dead_zone = 15'd1638;
      foreach (holdoff[i]) holdoff[i] = '0;
      arm_left = '0;
      expected_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) take_setting(cfg_index, cfg_data);
      if (in_valid && !in_stall) queue_word(condition_tick(in_data));
      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_ticks.size() == 0) begin
          miss_total++;
          if (miss_total <= 10)
            $display("result %0d arrived with nothing expected: %h", words_seen, out_data);
        end else begin
          want = expected_ticks.pop_front();
          cmp_field("action_pulses", want.action_pulses, out_data.action_pulses);
          cmp_field("arm_request", want.arm_request, out_data.arm_request);
          cmp_field("camera_valid", want.camera_valid, out_data.camera_valid);
          cmp_field("camera_tilt", want.camera_tilt, out_data.camera_tilt);
          cmp_field("camera_pan", want.camera_pan, out_data.camera_pan);
          cmp_field("hover", want.hover, out_data.hover);
          cmp_field("roll_out", want.roll_out, out_data.roll_out);
          cmp_field("pitch_out", want.pitch_out, out_data.pitch_out);
          cmp_field("yaw_out", want.yaw_out, out_data.yaw_out);
          cmp_field("climb_out", want.climb_out, out_data.climb_out);
        end
      end
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (expected_ticks.size() != 0) begin
          miss_total += expected_ticks.size();
          $display("%0d result words never arrived", expected_ticks.size());
        end
      end
    end
    pending <= expected_ticks.size();
    fail_count <= miss_total;
  end

endmodule

// ===== tb/sv/gamepad_flight_command_conditioner_unit_tb.sv =====
`timescale 1ns / 1ps

module gamepad_flight_command_conditioner_unit_tb;
  import gfcc_pkg::*;

  localparam int RANDOM_TICKS = 1600;
  localparam int PHASES = 8;
  // Far above the slowest legal run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int ONE = 1 << AXIS_FRAC_BITS_DEF;
  // Smallest magnitude that still counts as a held arming stick.
  localparam int GESTURE_MIN = (ONE * 9) / 10 + 1;
  localparam logic [8:0] ALL_ACTIONS = 9'h1FF;
  localparam logic [8:0] SLOW_BTN = 9'(1) << ACT_SLOW;
  localparam logic [8:0] CAMERA_BTN = 9'(1) << ACT_CAMERA;
  // Direction pairs: pitch plus and climb minus form the arming gesture
  localparam logic [7:0] DIR_GESTURE = 8'h24;
  localparam logic [7:0] DIR_GESTURE_CLASH = 8'h18;
  localparam logic [7:0] DIR_ALL_PLUS = 8'h55;
  localparam logic [7:0] DIR_ALL_MINUS = 8'hAA;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic wrap_up = 1'b0;
  int fail_count;
  int pending;

  // Idling knobs, set per phase by the stimulus process
  int idle_pct = 0;
  int stall_pct = 0;
  int long_hold_asks = 0;
  int long_hold_seen = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int ticks_sent = 0;

  always #10 clk = ~clk;

  gamepad_flight_command_conditioner_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gfcc_scoreboard command_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wrap_up    (wrap_up),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: honor a long hold-off request first (counted here), else stall at random.
  always @(posedge clk) begin
    if (long_hold_asks != long_hold_seen) begin
      long_hold_seen <= long_hold_asks;
      hold_left <= LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic cfg_t settings(input int ae, pm, axen, cam, hold, camh, arm, dz);
    cfg_t c;
    c.action_enable = ae[8:0];
    c.pair_mode = pm[3:0];
    c.axis_enable = axen[3:0];
    c.camera_supported = cam[0];
    c.hold_off_ticks = hold[7:0];
    c.camera_hold_off = camh[7:0];
    c.arm_hold_ticks = arm[6:0];
    c.dead_zone = dz[14:0];
    return c;
  endfunction

  // Mostly random settings with a fair share of the extremes; hold-offs kept short
  // so that actions keep firing.
  function automatic cfg_t random_settings();
    int ae, pm, axen, hold, camh, arm, dz;
    case ($urandom_range(0, 5))
      0: ae = 0;
      1: ae = ALL_ACTIONS;
      default: ae = $urandom_range(0, 511);
    endcase
    case ($urandom_range(0, 4))
      0: pm = 0;
      1: pm = 15;
      default: pm = $urandom_range(0, 15);
    endcase
    axen = ($urandom_range(0, 2) == 0) ? 15 : $urandom_range(0, 15);
    case ($urandom_range(0, 5))
      0: hold = 0;
      1: hold = 255;
      default: hold = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 5))
      0: camh = 0;
      1: camh = 255;
      default: camh = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 5))
      0: arm = 1;
      1: arm = 127;
      default: arm = $urandom_range(2, 12);
    endcase
    case ($urandom_range(0, 5))
      0: dz = 0;
      1: dz = ONE;
      2: dz = 1638;
      default: dz = $urandom_range(0, 4000);
    endcase
    return settings(ae, pm, axen, $urandom_range(0, 1), hold, camh, arm, dz);
  endfunction

  function automatic in_word_t make_tick(input logic present, input logic [8:0] btn,
                                         input logic [7:0] dir, input int r, p, h, y);
    in_word_t w;
    w.device_present = present;
    w.action_buttons = btn;
    w.direction_buttons = dir;
    w.roll_stick = r[15:0];
    w.pitch_stick = p[15:0];
    w.height_stick = h[15:0];
    w.yaw_stick = y[15:0];
    return w;
  endfunction

  // Stick value: mostly in range, with full-scale, near-center and raw 16-bit cases.
  function automatic int rand_axis();
    case ($urandom_range(0, 9))
      0: return ONE;
      1: return -ONE;
      2: return int'($urandom_range(0, 4000)) - 2000;
      3: return int'($urandom_range(0, 65535)) - 32768;
      default: return int'($urandom_range(0, 2 * ONE)) - ONE;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write every register; only call this with nothing in flight.
  task automatic load_settings(input cfg_t c);
    write_reg(REG_ACTION_ENABLE, c.action_enable);
    write_reg(REG_PAIR_MODE, c.pair_mode);
    write_reg(REG_AXIS_ENABLE, c.axis_enable);
    write_reg(REG_CAMERA_SUPPORTED, c.camera_supported);
    write_reg(REG_HOLD_OFF_TICKS, c.hold_off_ticks);
    write_reg(REG_CAMERA_HOLD_OFF, c.camera_hold_off);
    write_reg(REG_ARM_HOLD_TICKS, c.arm_hold_ticks);
    write_reg(REG_DEAD_ZONE, c.dead_zone);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word after a random gap; hold it until it is taken.
  task automatic send_tick(input in_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // Pause the sender until every result word is back, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic noise_tick();
    send_tick(make_tick($urandom_range(0, 19) != 0, 9'($urandom & $urandom), 8'($urandom),
                        rand_axis(), rand_axis(), rand_axis(), rand_axis()));
  endtask

  // Hold the arming gesture for a while; drop slow and camera most of the time
  // since they would break it, and lose the gamepad now and then.
  task automatic gesture_run(input int len);
    logic [8:0] btn;
    logic [7:0] dir;
    for (int k = 0; k < len; k++) begin
      btn = 9'($urandom & $urandom);
      if ($urandom_range(0, 4) != 0) btn = btn & ~(SLOW_BTN | CAMERA_BTN);
      dir = (8'($urandom) | DIR_GESTURE) & ~DIR_GESTURE_CLASH;
      send_tick(make_tick($urandom_range(0, 29) != 0, btn, dir, rand_axis(),
                          $urandom_range(GESTURE_MIN, ONE), $urandom_range(GESTURE_MIN, ONE),
                          rand_axis()));
    end
  endtask

  // Keep a button set held so that the hold-off counters gate repeats.
  task automatic press_run(input int len);
    logic [8:0] btn;
    btn = (9'(1) << $urandom_range(0, N_ACT - 1)) | 9'($urandom & $urandom & $urandom);
    for (int k = 0; k < len; k++)
      send_tick(make_tick(1'b1, btn, 8'($urandom),
                          rand_axis(), rand_axis(), rand_axis(), rand_axis()));
  endtask

  initial begin
    int phase_start;
    int target;
    logic hold_asked;
    hold_asked = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: sticks on every axis, no hold-off, arm on first gesture tick, no dead zone.
    load_settings(settings(ALL_ACTIONS, 0, 15, 1, 0, 0, 1, 0));
    send_tick(make_tick(1'b0, ALL_ACTIONS, 8'hFF, ONE, ONE, ONE, ONE));
    send_tick(make_tick(1'b1, '0, '0, ONE, ONE, -ONE, ONE));
    send_tick(make_tick(1'b1, '0, '0, -ONE, -ONE, ONE, -ONE));
    // Out of range sticks saturate, the negated height stick included.
    send_tick(make_tick(1'b1, '0, '0, 32767, -32768, -32768, 32767));
    send_tick(make_tick(1'b1, '0, '0, 0, 0, 0, 0));
    for (int i = 0; i < N_ACT; i++)
      send_tick(make_tick(1'b1, 9'(1) << i, '0, 10000, -9000, 7000, -5000));
    send_tick(make_tick(1'b1, '0, '0, 0, ONE, ONE, 0));
    send_tick(make_tick(1'b1, '0, '0, 0, ONE, ONE, 0));
    send_tick(make_tick(1'b1, SLOW_BTN | CAMERA_BTN, '0, ONE, -ONE, -ONE, ONE));
    send_tick(make_tick(1'b1, CAMERA_BTN, '0, 5000, 5000, -12345, 9999));
    drain();

    // Directed: button pairs, longest hold-offs, a full-scale dead zone, no camera support.
    load_settings(settings(ALL_ACTIONS, 15, 0, 0, 255, 255, 127, ONE));
    send_tick(make_tick(1'b1, '0, DIR_ALL_PLUS, 0, 0, 0, 0));
    send_tick(make_tick(1'b1, '0, DIR_ALL_MINUS, 0, 0, 0, 0));
    send_tick(make_tick(1'b1, '0, 8'hFF, 0, 0, 0, 0));
    send_tick(make_tick(1'b1, ALL_ACTIONS, DIR_GESTURE, 0, 0, 0, 0));
    send_tick(make_tick(1'b1, ALL_ACTIONS, DIR_GESTURE, 0, 0, 0, 0));
    drain();

    // Directed: nothing mapped to actions, dead zone edge at its default.
    load_settings(settings(0, 0, 15, 1, 16, 8, 100, 1638));
    send_tick(make_tick(1'b1, ALL_ACTIONS, '0, 1637, -1638, 1638, -1637));
    send_tick(make_tick(1'b1, ALL_ACTIONS, '0, -1637, 1638, -1638, 1637));
    drain();

    // Random phases, each with its own settings and idling pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      load_settings(random_settings());
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 74; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 74; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      phase_start = ticks_sent;
      target = RANDOM_TICKS / PHASES;
      while (ticks_sent - phase_start < target) begin
        // Stall the receiver for a long stretch while words keep coming, to back up the input.
        if (ph == 4 && !hold_asked && ticks_sent - phase_start >= 50) begin
          hold_asked = 1'b1;
          long_hold_asks++;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: gesture_run($urandom_range(1, 8));
          4, 5: press_run($urandom_range(2, 6));
          default: noise_tick();
        endcase
      end
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gfcc_pkg.sv
src/gfcc_axis.sv
src/gfcc_ctrl.sv
src/gamepad_flight_command_conditioner_unit.sv
src/gfcc_checker.sv
tb/sv/gfcc_checker.sv
tb/sv/gamepad_flight_command_conditioner_unit_tb.sv
